@@ sv/qte_pkg.sv @@
// qte_pkg: constants, widths and the arctangent table for the quaternion to euler block
// used by qte_vec_stage, qte_cordic_chain and quaternion_to_euler_angles
`default_nettype none
package qte_pkg;

  localparam int CORDIC_STEPS    = 16;
  localparam int ANGLE_FRAC_BITS = 7;
  localparam int ATAN_TABLE_LEN  = 24;
  localparam int XY_W            = 37;
  localparam int Z_W             = 34;
  localparam logic [23:0] GAIN_INV_Q24 = 24'd10188014;

  // atan(2^-i) in binary angle units, 2^32 per turn
  function automatic logic [31:0] atan_brad(input int idx);
    logic [31:0] t;
    case (idx)
      0:       t = 32'h20000000;
      1:       t = 32'h12E4051E;
      2:       t = 32'h09FB385B;
      3:       t = 32'h051111D4;
      4:       t = 32'h028B0D43;
      5:       t = 32'h0145D7E1;
      6:       t = 32'h00A2F61E;
      7:       t = 32'h00517C55;
      8:       t = 32'h0028BE53;
      9:       t = 32'h00145F2F;
      10:      t = 32'h000A2F98;
      11:      t = 32'h000517CC;
      12:      t = 32'h00028BE6;
      13:      t = 32'h000145F3;
      14:      t = 32'h0000A2F9;
      15:      t = 32'h0000517C;
      16:      t = 32'h000028BE;
      17:      t = 32'h0000145F;
      18:      t = 32'h00000A2F;
      19:      t = 32'h00000517;
      20:      t = 32'h0000028B;
      21:      t = 32'h00000145;
      22:      t = 32'h000000A2;
      23:      t = 32'h00000051;
      default: t = 32'h00000000;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

@@ sv/qte_vec_stage.sv @@
// qte_vec_stage: one registered cordic vectoring step
// depends on qte_pkg
`default_nettype none
module qte_vec_stage #(
  parameter int IDX = 0
) (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic signed [qte_pkg::XY_W-1:0]   x_i,
  input  wire logic signed [qte_pkg::XY_W-1:0]   y_i,
  input  wire logic signed [qte_pkg::Z_W-1:0]    z_i,
  output logic signed [qte_pkg::XY_W-1:0]        x_r,
  output logic signed [qte_pkg::XY_W-1:0]        y_r,
  output logic signed [qte_pkg::Z_W-1:0]         z_r
);

  localparam logic [31:0] TBL = qte_pkg::atan_brad(IDX);

  logic signed [qte_pkg::XY_W-1:0] dx, dy, x_nxt, y_nxt;
  logic signed [qte_pkg::Z_W-1:0]  t, z_nxt;

  always_comb begin
    dx = y_i >>> IDX;
    dy = x_i >>> IDX;
    t  = {{(qte_pkg::Z_W-32){1'b0}}, TBL};
    if (!y_i[qte_pkg::XY_W-1]) begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + t;
    end else begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - t;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

endmodule
`default_nettype wire

@@ sv/qte_cordic_chain.sv @@
// qte_cordic_chain: pipelined cordic vectoring, one register stage per step
// depends on qte_pkg and qte_vec_stage
`default_nettype none
module qte_cordic_chain #(
  parameter int STEPS = qte_pkg::CORDIC_STEPS
) (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic signed [qte_pkg::XY_W-1:0]   x_i,
  input  wire logic signed [qte_pkg::XY_W-1:0]   y_i,
  input  wire logic signed [qte_pkg::Z_W-1:0]    z_i,
  output logic signed [qte_pkg::XY_W-1:0]        x_o,
  output logic signed [qte_pkg::Z_W-1:0]         z_o
);

  logic signed [qte_pkg::XY_W-1:0] x [STEPS+1];
  logic signed [qte_pkg::XY_W-1:0] y [STEPS];
  logic signed [qte_pkg::Z_W-1:0]  z [STEPS+1];

  assign x[0] = x_i;
  assign y[0] = y_i;
  assign z[0] = z_i;
  assign x_o  = x[STEPS];
  assign z_o  = z[STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    if (k < STEPS-1) begin : g_mid
      qte_vec_stage #(.IDX(k)) u_stage (
        .clk(clk), .en(en), .x_i(x[k]), .y_i(y[k]), .z_i(z[k]),
        .x_r(x[k+1]), .y_r(y[k+1]), .z_r(z[k+1])
      );
    end else begin : g_last
      qte_vec_stage #(.IDX(k)) u_stage (
        .clk(clk), .en(en), .x_i(x[k]), .y_i(y[k]), .z_i(z[k]),
        .x_r(x[k+1]), .y_r(), .z_r(z[k+1])
      );
    end
  end

endmodule
`default_nettype wire

@@ sv/quaternion_to_euler_angles.sv @@
// quaternion_to_euler_angles: quaternion in, pitch/roll/yaw out, fully pipelined cordic
// depends on qte_pkg and qte_cordic_chain
//
//  channel | ports                                   | direction
//  in      | in_valid in_ready in_q_w/x/y/z          | quaternion, Q2.14
//  out     | out_valid out_ready out_pitch/roll/yaw_deg | angles, 1/2^F degree
//
// pipe stages, with S = min(CORDIC_STEPS, 24): products, sums,
// abs/rotate, S magnitude steps, two gain-multiply stages, S atan steps,
// scale and round; one transaction per cycle while the output is not stalled
// rst_n clears only the valid bits
// the whole pipe advances whenever the output register is empty or taken
`default_nettype none
module quaternion_to_euler_angles #(
  parameter int CORDIC_STEPS    = qte_pkg::CORDIC_STEPS,
  parameter int ANGLE_FRAC_BITS = qte_pkg::ANGLE_FRAC_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_q_w,
  input  wire logic signed [15:0] in_q_x,
  input  wire logic signed [15:0] in_q_y,
  input  wire logic signed [15:0] in_q_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [14:0]      out_pitch_deg,
  output logic signed [14:0]      out_roll_deg,
  output logic signed [15:0]      out_yaw_deg
);

  localparam int XW = qte_pkg::XY_W;
  localparam int ZW = qte_pkg::Z_W;
  localparam int NS = (CORDIC_STEPS > qte_pkg::ATAN_TABLE_LEN) ?
                      qte_pkg::ATAN_TABLE_LEN : CORDIC_STEPS;
  localparam int D  = 2*NS + 7;
  localparam logic signed [ZW-1:0] QUARTER = {{(ZW-31){1'b0}}, 1'b1, 30'b0};
  localparam logic signed [40:0]   RND     = 41'sd1 <<< (28 - ANGLE_FRAC_BITS);

  function automatic logic signed [33:0] ext34(input logic signed [31:0] a);
    return {{2{a[31]}}, a};
  endfunction

  function automatic logic signed [15:0] sat_angle(input logic signed [40:0] v,
                                                   input int w);
    logic signed [40:0] hi, lo, r;
    hi = (41'sd1 <<< (w-1)) - 41'sd1;
    lo = -(41'sd1 <<< (w-1));
    r  = (v > hi) ? hi : ((v < lo) ? lo : v);
    return r[15:0];
  endfunction

  logic         en;
  logic [D-1:0] v_r;

  assign en        = !v_r[D-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = v_r[D-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[D-2:0], in_valid};
    end
  end

  // products
  logic signed [31:0] p13_r, p02_r, p01_r, p23_r, p00_r, p11_r, p22_r, p33_r, p12_r, p03_r;
  always_ff @(posedge clk) begin
    if (en) begin
      p13_r <= in_q_x * in_q_z;
      p02_r <= in_q_w * in_q_y;
      p01_r <= in_q_w * in_q_x;
      p23_r <= in_q_y * in_q_z;
      p00_r <= in_q_w * in_q_w;
      p11_r <= in_q_x * in_q_x;
      p22_r <= in_q_y * in_q_y;
      p33_r <= in_q_z * in_q_z;
      p12_r <= in_q_x * in_q_y;
      p03_r <= in_q_w * in_q_z;
    end
  end

  // gravity vector and yaw arguments
  logic signed [33:0] gx2_r, gy2_r, gz2_r, yy2_r, yx2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      gx2_r <= (ext34(p13_r) - ext34(p02_r)) <<< 1;
      gy2_r <= (ext34(p01_r) + ext34(p23_r)) <<< 1;
      gz2_r <= ext34(p00_r) - ext34(p11_r) - ext34(p22_r) + ext34(p33_r);
      yy2_r <= (ext34(p12_r) - ext34(p03_r)) <<< 1;
      yx2_r <= ((ext34(p00_r) + ext34(p11_r)) <<< 1) - 34'sd268435456;
    end
  end

  // abs values and yaw quadrant rotation
  logic signed [XW-1:0] agx3_r, agy3_r, agz3_r, yx3_r, yy3_r;
  logic signed [XW-1:0] gx3_r, gy3_r, ex, ey, ey_x_nxt, ey_y_nxt;
  logic signed [ZW-1:0] yz3_r, yz_nxt;
  logic                 yzero3_r;

  always_comb begin
    ex       = {{(XW-34){yx2_r[33]}}, yx2_r};
    ey       = {{(XW-34){yy2_r[33]}}, yy2_r};
    ey_x_nxt = ex;
    ey_y_nxt = ey;
    yz_nxt   = '0;
    if (yx2_r[33]) begin
      if (!yy2_r[33]) begin
        ey_x_nxt = ey;
        ey_y_nxt = -ex;
        yz_nxt   = QUARTER;
      end else begin
        ey_x_nxt = -ey;
        ey_y_nxt = ex;
        yz_nxt   = -QUARTER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gx3_r    <= {{(XW-34){gx2_r[33]}}, gx2_r};
      gy3_r    <= {{(XW-34){gy2_r[33]}}, gy2_r};
      agx3_r   <= gx2_r[33] ? -{{(XW-34){gx2_r[33]}}, gx2_r} : {{(XW-34){1'b0}}, gx2_r};
      agy3_r   <= gy2_r[33] ? -{{(XW-34){gy2_r[33]}}, gy2_r} : {{(XW-34){1'b0}}, gy2_r};
      agz3_r   <= gz2_r[33] ? -{{(XW-34){gz2_r[33]}}, gz2_r} : {{(XW-34){1'b0}}, gz2_r};
      yx3_r    <= ey_x_nxt;
      yy3_r    <= ey_y_nxt;
      yz3_r    <= yz_nxt;
      yzero3_r <= (yx2_r == '0) && (yy2_r == '0);
    end
  end

  // magnitudes and yaw angle
  logic signed [XW-1:0] mp_x, mr_x;
  logic signed [ZW-1:0] yaw_z;

  qte_cordic_chain #(.STEPS(NS)) u_mag_pitch (
    .clk(clk), .en(en), .x_i(agy3_r), .y_i(agz3_r), .z_i('0), .x_o(mp_x), .z_o()
  );
  qte_cordic_chain #(.STEPS(NS)) u_mag_roll (
    .clk(clk), .en(en), .x_i(agx3_r), .y_i(agz3_r), .z_i('0), .x_o(mr_x), .z_o()
  );
  qte_cordic_chain #(.STEPS(NS)) u_yaw (
    .clk(clk), .en(en), .x_i(yx3_r), .y_i(yy3_r), .z_i(yz3_r), .x_o(), .z_o(yaw_z)
  );

  logic signed [XW-1:0] gxd_r [NS+2];
  logic signed [XW-1:0] gyd_r [NS+2];
  logic                 yzl_r [NS];
  logic signed [ZW-1:0] ywd_r [NS+2];

  always_ff @(posedge clk) begin
    if (en) begin
      gxd_r[0] <= gx3_r;
      gyd_r[0] <= gy3_r;
      ywd_r[0] <= yzl_r[NS-1] ? '0 : yaw_z;
      for (int k = 1; k < NS+2; k++) begin
        gxd_r[k] <= gxd_r[k-1];
        gyd_r[k] <= gyd_r[k-1];
        ywd_r[k] <= ywd_r[k-1];
      end
      yzl_r[0] <= yzero3_r;
      for (int k = 1; k < NS; k++) begin
        yzl_r[k] <= yzl_r[k-1];
      end
    end
  end

  // gain correction, split into two partial products
  logic [41:0]          pa_p_r, pb_p_r, pa_r_r, pb_r_r;
  logic [60:0]          sum_p, sum_r;
  logic signed [XW-1:0] mag_p_r, mag_r_r;

  always_comb begin
    sum_p = {1'b0, pb_p_r, 18'b0} + {19'b0, pa_p_r} + (61'd1 << 23);
    sum_r = {1'b0, pb_r_r, 18'b0} + {19'b0, pa_r_r} + (61'd1 << 23);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_p_r  <= {24'b0, mp_x[17:0]} * {18'b0, qte_pkg::GAIN_INV_Q24};
      pb_p_r  <= {24'b0, mp_x[XW-2:18]} * {18'b0, qte_pkg::GAIN_INV_Q24};
      pa_r_r  <= {24'b0, mr_x[17:0]} * {18'b0, qte_pkg::GAIN_INV_Q24};
      pb_r_r  <= {24'b0, mr_x[XW-2:18]} * {18'b0, qte_pkg::GAIN_INV_Q24};
      mag_p_r <= sum_p[24 +: XW];
      mag_r_r <= sum_r[24 +: XW];
    end
  end

  // pitch and roll angles
  logic signed [ZW-1:0] pitch_z, roll_z;
  logic                 zp_r [NS];
  logic                 zr_r [NS];

  qte_cordic_chain #(.STEPS(NS)) u_atan_pitch (
    .clk(clk), .en(en), .x_i(mag_p_r), .y_i(gxd_r[NS+1]), .z_i('0), .x_o(), .z_o(pitch_z)
  );
  qte_cordic_chain #(.STEPS(NS)) u_atan_roll (
    .clk(clk), .en(en), .x_i(mag_r_r), .y_i(gyd_r[NS+1]), .z_i('0), .x_o(), .z_o(roll_z)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      zp_r[0] <= (mag_p_r == '0) && (gxd_r[NS+1] == '0);
      zr_r[0] <= (mag_r_r == '0) && (gyd_r[NS+1] == '0);
      for (int k = 1; k < NS; k++) begin
        zp_r[k] <= zp_r[k-1];
        zr_r[k] <= zr_r[k-1];
      end
    end
  end

  // scale to degrees, round and saturate
  logic signed [ZW-1:0] zp_sel, zr_sel;
  logic signed [40:0]   sp_r, sr_r, sy_r, rp, rr, ry;

  always_comb begin
    zp_sel = zp_r[NS-1] ? '0 : pitch_z;
    zr_sel = zr_r[NS-1] ? '0 : roll_z;
    rp     = (sp_r + RND) >>> (29 - ANGLE_FRAC_BITS);
    rr     = (sr_r + RND) >>> (29 - ANGLE_FRAC_BITS);
    ry     = (sy_r + RND) >>> (29 - ANGLE_FRAC_BITS);
  end

  logic signed [15:0] op, orr;

  assign op  = sat_angle(rp, 15);
  assign orr = sat_angle(rr, 15);

  always_ff @(posedge clk) begin
    if (en) begin
      sp_r          <= {{(41-ZW){zp_sel[ZW-1]}}, zp_sel} * 41'sd45;
      sr_r          <= {{(41-ZW){zr_sel[ZW-1]}}, zr_sel} * 41'sd45;
      sy_r          <= {{(41-ZW){ywd_r[NS+1][ZW-1]}}, ywd_r[NS+1]} * 41'sd45;
      out_pitch_deg <= op[14:0];
      out_roll_deg  <= orr[14:0];
      out_yaw_deg   <= sat_angle(ry, 16);
    end
  end

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v_r[0])
    else $error("accepted transaction not entered in pipe");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("valid after reset");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input blocked without output stall");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_r))
    else $error("pipe moved during stall");

endmodule
`default_nettype wire
